FILE: rtl/b64e_pkg.sv
// Shared types, constants and the base64 symbol function for the encoder.
// Used by b64e_group, b64e_serial and base64_encoder_line_wrap.
package b64e_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       is_last;
	} b64e_in_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       run_end;
	} b64e_out_t;

	// One encoded group: four characters (index 0 goes first) and a line-break flag.
	typedef struct packed {
		logic [3:0][7:0] chars;
		logic            brk;
	} b64e_group_t;

	localparam logic REG_HEADER_MODE = 1'b0;
	localparam logic REG_LINE_LIMIT  = 1'b1;

	localparam logic [7:0] CH_PAD   = 8'h3D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	localparam logic [7:0] LIMIT_RESET = 8'd76;
	localparam logic [8:0] COUNT_START = 9'd4;
	localparam logic [8:0] COUNT_MAX   = 9'd511;

	// Position of the last character in the serializer buffer.
	localparam logic [2:0] LAST_NO_BRK = 3'd3;
	localparam logic [2:0] LAST_BRK    = 3'd5;
	localparam logic [2:0] IDX_CR      = 3'd4;

	function automatic logic [7:0] b64_symbol(input logic [5:0] v);
		logic [7:0] w;
		begin
			w = {2'b00, v};
			if (v < 6'd26)
				return w + 8'd65;       // A-Z
			else if (v < 6'd52)
				return w + 8'd71;       // a-z
			else if (v < 6'd62)
				return w - 8'd4;        // 0-9
			else if (v == 6'd62)
				return CH_PLUS;
			else
				return CH_SLASH;
		end
	endfunction

endpackage

FILE: rtl/b64e_group.sv
// Byte gatherer and group encoder: holds bytes, tracks line count, registers one group.
// Depends on b64e_pkg.
module b64e_group (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  src_valid,
	output logic                  src_stall,
	input  b64e_pkg::b64e_in_t    src_data,
	input  logic                  header_mode,
	input  logic [7:0]            line_limit,
	input  logic                  ser_ready,
	output logic                  grp_valid,
	output b64e_pkg::b64e_group_t grp
);
	import b64e_pkg::*;

	logic [15:0]  held_q;
	logic [1:0]   pos_q;
	logic [8:0]   line_count_q;
	logic         grp_valid_s1;
	b64e_group_t  grp_s1;

	logic [1:0]   pos_eff;
	logic         complete;
	logic         accept;
	logic         load;
	logic [23:0]  word;
	logic [9:0]   count_sum;
	logic [8:0]   count_sat;
	logic         brk;
	b64e_group_t  grp_next;

	assign load      = grp_valid_s1 & ser_ready;
	assign src_stall = grp_valid_s1 & ~ser_ready;
	assign accept    = src_valid & ~src_stall;

	// Position 3 never arises; treated like 2.
	assign pos_eff  = (pos_q == 2'd3) ? 2'd2 : pos_q;
	assign complete = src_data.is_last | (pos_eff == 2'd2);

	always_comb begin
		case (pos_eff)
			2'd0:    word = {src_data.in_byte, 16'h0000};
			2'd1:    word = {held_q, 8'h00} | {8'h00, src_data.in_byte, 8'h00};
			default: word = {held_q, src_data.in_byte};
		endcase
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			if (k > int'(pos_eff) + 1)
				grp_next.chars[k] = CH_PAD;
			else
				grp_next.chars[k] = b64_symbol(word[23 - 6*k -: 6]);
		end
		grp_next.brk = brk;
	end

	assign count_sum = {1'b0, line_count_q} + 10'd4;
	assign count_sat = count_sum[9] ? COUNT_MAX : count_sum[8:0];
	assign brk       = ~header_mode & (count_sat > {1'b0, line_limit});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= '0;
			pos_q        <= '0;
			line_count_q <= COUNT_START;
			grp_valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (!complete) begin
					if (pos_eff == 2'd0)
						held_q <= {src_data.in_byte, 8'h00};
					else
						held_q <= {held_q[15:8], src_data.in_byte};
					pos_q <= pos_eff + 2'd1;
				end else begin
					held_q       <= '0;
					pos_q        <= '0;
					line_count_q <= (brk || src_data.is_last) ? COUNT_START : count_sat;
				end
			end
			if (accept && complete)
				grp_valid_s1 <= 1'b1;
			else if (load)
				grp_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && complete)
			grp_s1 <= grp_next;
	end

	assign grp_valid = grp_valid_s1;
	assign grp       = grp_s1;

endmodule

FILE: rtl/b64e_serial.sv
// Output serializer: a group's four chars and optional CR LF, one per unstalled cycle.
// Depends on b64e_pkg.
module b64e_serial (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  grp_valid,
	input  b64e_pkg::b64e_group_t grp,
	output logic                  ser_ready,
	output logic                  dst_valid,
	input  logic                  dst_stall,
	output b64e_pkg::b64e_out_t   dst_data
);
	import b64e_pkg::*;

	logic            busy_q;
	logic [2:0]      idx_q;
	logic [2:0]      last_q;
	logic [3:0][7:0] chars_q;

	logic fire;
	logic done;
	logic load;

	assign fire      = busy_q & ~dst_stall;
	assign done      = fire & (idx_q == last_q);
	assign ser_ready = ~busy_q | done;
	assign load      = grp_valid & ser_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			last_q <= LAST_NO_BRK;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
				last_q <= grp.brk ? LAST_BRK : LAST_NO_BRK;
			end else if (done) begin
				busy_q <= 1'b0;
			end else if (fire) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			chars_q <= grp.chars;
	end

	always_comb begin
		case (idx_q)
			3'd0:    dst_data.out_char = chars_q[0];
			3'd1:    dst_data.out_char = chars_q[1];
			3'd2:    dst_data.out_char = chars_q[2];
			3'd3:    dst_data.out_char = chars_q[3];
			IDX_CR:  dst_data.out_char = CH_CR;
			default: dst_data.out_char = CH_LF;
		endcase
		dst_data.run_end = (idx_q == last_q);
	end

	assign dst_valid = busy_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q <= last_q) else $error("char index past end of group");
	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy_q && idx_q == 3'd0) else $error("group load did not restart index");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done && !grp_valid |=> !busy_q) else $error("serializer stayed busy after last char");
	a_last_code: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> last_q == LAST_NO_BRK || last_q == LAST_BRK)
		else $error("bad group length");

endmodule

FILE: rtl/base64_encoder_line_wrap.sv
// Top level of the streaming base64 encoder with CR LF line wrapping.
// Depends on b64e_pkg, b64e_group and b64e_serial.
//
// Bytes come in on the src channel one request per cycle while src_stall is low;
// every third byte, or a byte flagged is_last, closes a group that is encoded in a
// single registered pass into four base64 characters (padded with '=' for a short
// final group), plus CR LF when the running line count plus four passes
// line_limit and header_mode is clear. Characters leave on the dst channel one
// per cycle while dst_stall is low, with run_end on the last character of each
// group. A closed group is registered in the group stage and then loaded into
// the serializer before its first character can be taken. One encoded group
// waits in a register ahead of the serializer, so the next bytes are taken while
// a group drains; a further group that closes before the serializer frees up
// stalls src. The two configuration registers are written through
// cfg_we/cfg_index/cfg_data (index 0 header_mode from cfg_data[0], index 1
// line_limit); the user must write them only while idle, as the block does not
// enforce this. Each message ends with the line count back at its start value.
module base64_encoder_line_wrap (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_stall,
	input  b64e_pkg::b64e_in_t  src_data,
	output logic                dst_valid,
	input  logic                dst_stall,
	output b64e_pkg::b64e_out_t dst_data,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [7:0]          cfg_data
);
	import b64e_pkg::*;

	logic        header_mode_q;
	logic [7:0]  line_limit_q;

	logic        grp_valid;
	logic        ser_ready;
	b64e_group_t grp;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_mode_q <= 1'b0;
			line_limit_q  <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEADER_MODE: header_mode_q <= cfg_data[0];
				REG_LINE_LIMIT:  line_limit_q  <= cfg_data;
				default:         line_limit_q  <= line_limit_q;
			endcase
		end
	end

	// gather and encode
	b64e_group u_group (
		.clk         (clk),
		.arst_n      (arst_n),
		.src_valid   (src_valid),
		.src_stall   (src_stall),
		.src_data    (src_data),
		.header_mode (header_mode_q),
		.line_limit  (line_limit_q),
		.ser_ready   (ser_ready),
		.grp_valid   (grp_valid),
		.grp         (grp)
	);

	// one character per cycle out while dst_stall is low
	b64e_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp_valid (grp_valid),
		.grp       (grp),
		.ser_ready (ser_ready),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_data  (dst_data)
	);

endmodule

FILE: verif/b64e_checker.sv
`timescale 1ns / 1ps
// Scoreboard for base64_encoder_line_wrap: mirrors register writes, encodes each
// accepted byte request and compares every character that leaves the dst channel.
// Depends on b64e_pkg for the payload types, register indexes and characters.
module b64e_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	input  logic                src_stall,
	input  b64e_pkg::b64e_in_t  src_data,
	input  logic                dst_valid,
	input  logic                dst_stall,
	input  b64e_pkg::b64e_out_t dst_data,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [7:0]          cfg_data,
	output int                  errors,
	output int                  pending
);
	import b64e_pkg::*;

	b64e_out_t encoded_chars[$];

	logic       hdr_mode   = 1'b0;
	logic [7:0] wrap_limit = LIMIT_RESET;
	logic [15:0] pend_bytes = '0;
	logic [1:0] grp_pos    = '0;
	logic [8:0] col_count  = COUNT_START;
	int         err_count  = 0;

	function automatic logic [7:0] sextet_char(input logic [5:0] s);
		logic [7:0] v;
		v = {2'b00, s};
		if (v <= 8'd25)
			return 8'h41 + v;
		if (v <= 8'd51)
			return 8'h61 + (v - 8'd26);
		if (v <= 8'd61)
			return 8'h30 + (v - 8'd52);
		return (v == 8'd62) ? CH_PLUS : CH_SLASH;
	endfunction

	task automatic push_char(input logic [7:0] c);
		b64e_out_t r;
		r.out_char = c;
		r.run_end  = 1'b0;
		encoded_chars.push_back(r);
	endtask

	task automatic encode_byte(input b64e_in_t it);
		int         p;
		int         taken;
		logic [23:0] word;
		logic [9:0] sum;
		b64e_out_t  tail;
		p = (grp_pos == 2'd3) ? 2 : int'(grp_pos);
		if (!it.is_last && p < 2) begin
			if (p == 0)
				pend_bytes = {it.in_byte, 8'h00};
			else
				pend_bytes[7:0] = it.in_byte;
			grp_pos = 2'(p + 1);
			return;
		end
		taken = p + 1;
		word  = {pend_bytes, 8'h00} | ({16'h0000, it.in_byte} << (8 * (2 - p)));
		for (int k = 0; k < 4; k++) begin
			if (k > taken)
				push_char(CH_PAD);
			else
				push_char(sextet_char(word[(18 - 6 * k) +: 6]));
		end
		// count saturates so a long header-mode run cannot wrap around
		sum = {1'b0, col_count} + 10'd4;
		col_count = (sum > 10'd511) ? COUNT_MAX : sum[8:0];
		if (!hdr_mode && col_count > {1'b0, wrap_limit}) begin
			push_char(CH_CR);
			push_char(CH_LF);
			col_count = COUNT_START;
		end
		pend_bytes = '0;
		grp_pos    = '0;
		if (it.is_last)
			col_count = COUNT_START;
		tail = encoded_chars.pop_back();
		tail.run_end = 1'b1;
		encoded_chars.push_back(tail);
	endtask

	always @(posedge clk or negedge arst_n) begin
		b64e_out_t want;
		if (!arst_n) begin
			encoded_chars.delete();
			hdr_mode   = 1'b0;
			wrap_limit = LIMIT_RESET;
			pend_bytes = '0;
			grp_pos    = '0;
			col_count  = COUNT_START;
		end else begin
			if (dst_valid && !dst_stall) begin
				if (encoded_chars.size() == 0) begin
					err_count++;
					$error("out_char: expected none, got 8'h%02h", dst_data.out_char);
				end else begin
					want = encoded_chars.pop_front();
					if (dst_data.out_char !== want.out_char) begin
						err_count++;
						$error("out_char: expected 8'h%02h, got 8'h%02h",
							want.out_char, dst_data.out_char);
					end
					if (dst_data.run_end !== want.run_end) begin
						err_count++;
						$error("run_end: expected %0b, got %0b",
							want.run_end, dst_data.run_end);
					end
				end
			end
			if (src_valid && !src_stall)
				encode_byte(src_data);
			if (cfg_we) begin
				case (cfg_index)
					REG_HEADER_MODE: hdr_mode = cfg_data[0];
					REG_LINE_LIMIT:  wrap_limit = cfg_data;
					default: ;
				endcase
			end
		end
		errors  <= err_count;
		pending <= encoded_chars.size();
	end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Top of the base64_encoder_line_wrap testbench: clock, reset, byte requests,
// register writes and the verdict. Checking lives in b64e_checker; uses b64e_pkg.
module tb_top;
	import b64e_pkg::*;

	// Longest stretch without any accepted request that a healthy run can show.
	localparam int QUIET_LIMIT = 600;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       src_valid;
	logic       src_stall;
	b64e_in_t   src_data;
	logic       dst_valid;
	logic       dst_stall = 1'b0;
	b64e_out_t  dst_data;
	logic       cfg_we;
	logic       cfg_index;
	logic [7:0] cfg_data;

	int   errors;
	int   pending;
	logic idle_on = 1'b1;   // random idling on both channels while set
	int   stall_run = 0;
	int   quiet = 0;

	always #10 clk = ~clk;

	base64_encoder_line_wrap dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_data (src_data),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_data (dst_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	b64e_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_data (src_data),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_data (dst_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.errors   (errors),
		.pending  (pending)
	);

	// Receiver back-pressure: random bursts of stalled cycles, none once idling is off.
	always @(posedge clk) begin
		if (!idle_on || !arst_n) begin
			stall_run = 0;
			dst_stall <= 1'b0;
		end else if (stall_run > 0) begin
			stall_run--;
			dst_stall <= 1'b1;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_run = $urandom_range(1, 13) - 1;
			dst_stall <= 1'b1;
		end else begin
			dst_stall <= 1'b0;
		end
	end

	// Watchdog: a hung block shows up as a long run of cycles with no request moving.
	always @(posedge clk) begin
		if (!arst_n || (src_valid && !src_stall) || (dst_valid && !dst_stall))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Offer one byte request, maybe after a sender gap, and return at the edge that
	// takes it. valid stays high into the next call, so back-to-back requests never
	// see valid dip.
	task automatic push_byte(input logic [7:0] b, input logic last);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			src_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_data  <= '{in_byte: b, is_last: last};
		do @(posedge clk); while (src_stall);
	endtask

	// Drain: stop offering, let every predicted character come out, then give the
	// block a few more cycles in case a held byte is still moving through it.
	task automatic wait_idle();
		src_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Registers only change while the block is drained.
	task automatic write_reg(input logic idx, input logic [7:0] val);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		int         msg_left;
		int         lim;
		logic       hm;
		msg_left  = 0;
		arst_n    = 1'b0;
		src_valid = 1'b0;
		src_data  = '0;
		cfg_we    = 1'b0;
		cfg_index = REG_HEADER_MODE;
		cfg_data  = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset settings (limit 76, breaks on).
		// One-byte final groups: two pads each, all-zero and all-one bytes.
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b1);
		// Two-byte final groups: one pad.
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b1);
		// Full groups mid-message, then a full final group with no pad.
		push_byte(8'h00, 1'b0);
		push_byte(8'h10, 1'b0);
		push_byte(8'h83, 1'b0);
		push_byte(8'hFB, 1'b0);
		push_byte(8'hEF, 1'b0);
		push_byte(8'hBE, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b1);

		// Smallest limit: every group breaks, including right after the final one.
		write_reg(REG_LINE_LIMIT, 8'd4);
		repeat (5) push_byte(8'($urandom), 1'b0);
		push_byte(8'($urandom), 1'b1);

		// Header mode: no breaks even at the smallest limit.
		write_reg(REG_HEADER_MODE, {7'($urandom), 1'b1});
		push_byte(8'($urandom), 1'b0);
		push_byte(8'($urandom), 1'b0);
		push_byte(8'($urandom), 1'b1);
		push_byte(8'($urandom), 1'b1);

		// Random phases. Messages run across phase boundaries, so a new limit can
		// land below a count that is already high.
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 6) begin
				// Header-mode run that carries the count past the limit, then
				// breaks back on: the next group must break.
				write_reg(REG_HEADER_MODE, {7'($urandom), 1'b1});
				repeat (60) push_byte(8'($urandom), 1'b0);
				write_reg(REG_HEADER_MODE, {7'($urandom), 1'b0});
				write_reg(REG_LINE_LIMIT, 8'd76);
				push_byte(8'($urandom), 1'b0);
				push_byte(8'($urandom), 1'b0);
				push_byte(8'($urandom), 1'b1);
				msg_left = 0;
			end
			if (ph == 7)
				idle_on <= 1'b0;   // last stretch runs flat out
			case (ph)
				0:       lim = 4;
				1:       lim = 255;
				3:       lim = 76;
				default: lim = $urandom_range(4, 255);
			endcase
			hm = (ph == 2) || ($urandom_range(0, 4) == 0);
			write_reg(REG_HEADER_MODE, {7'($urandom), hm});
			write_reg(REG_LINE_LIMIT, 8'(lim));
			repeat ($urandom_range(14, 22)) begin
				// mostly short messages, now and then a long one
				if (msg_left == 0)
					msg_left = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 90)
						: $urandom_range(1, 12);
				push_byte(8'($urandom), msg_left == 1);
				msg_left--;
			end
		end

		wait_idle();
		repeat (12) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
